// File: src/mbrm_pkg.sv
// ----------------------------------------------------------------------------
// mbrm_pkg: shared types and constants for the modbus rtu master framer
// operation codes, frame constants and the byte-wise crc16 update
// ----------------------------------------------------------------------------
`default_nettype none

package mbrm_pkg;

  // operation carried in the input tuser
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_RX    = 2'd2
  } op_t;

  // result kind carried in the output tuser
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [7:0]  FC_READ_HOLD  = 8'h03;
  localparam logic [7:0]  FC_WRITE_ONE  = 8'h06;
  localparam logic [15:0] READ_QUANTITY = 16'h0001;
  localparam int          RX_MIN_LEN    = 7;
  localparam int          RX_FRAME_MAX_DEF = 32;

  // byte count of one request frame
  localparam int          REQ_LEN       = 8;

  // one byte into a reflected crc16, lsb first
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/modbus_rtu_master_framer.sv
// ----------------------------------------------------------------------------
// modbus_rtu_master_framer: modbus rtu request framer and response checker
// builds read/write request frames with crc16 and checks response frames
// ----------------------------------------------------------------------------
// usage
//   s_* channel: one beat per command. tuser is the operation (read request,
//   write request, received response byte), tlast marks the last response
//   byte. a read or write request gives eight frame beats on m_*, one per
//   cycle unless stalled, crc low byte then high byte last with tlast. a response
//   byte gives nothing, except the one marked tlast, which gives one read
//   outcome beat (tuser set) carrying ok and the register value.
//   flow: a beat waits in the input register. a response byte puts its read
//   outcome from there straight into the output register; a request first
//   loads the emit sequencer, which then puts its frame bytes into the output
//   register one byte per cycle while the output is free; the next request
//   is loaded during the last emit step. each response byte is one byte-wide
//   crc update step.
//   stall: the output register holds its beat until m_tready; the input
//   register still takes one beat while the output waits.
//   reset: rst is synchronous; it empties both registers, stops any frame
//   in progress and returns the response checker to its cleared state.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_master_framer
  import mbrm_pkg::*;
#(
  parameter int RX_FRAME_MAX = RX_FRAME_MAX_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command input
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // slave_address, reg_address, write_value, rx_byte
  input  wire logic [1:0]  s_tuser,  // operation
  input  wire logic        s_tlast,  // rx_end
  // result output
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // frame_byte, read_ok, read_value, zero pad
  output logic             m_tuser,  // result_kind
  output logic             m_tlast   // frame_last
);

  localparam int CW = $clog2(RX_FRAME_MAX + 1);

  // input register
  logic        in_valid;
  logic [1:0]  in_op;
  logic [7:0]  in_slave;
  logic [15:0] in_addr;
  logic [15:0] in_wval;
  logic [7:0]  in_rxb;
  logic        in_end;

  // request emit sequencer
  logic        tx_busy;
  logic [2:0]  tx_idx;
  logic [7:0]  tx_slave;
  logic [7:0]  tx_fc;
  logic [15:0] tx_addr;
  logic [15:0] tx_word;
  logic [15:0] tx_crc;

  // response checker
  logic [CW-1:0] rx_count;
  logic [15:0]   rx_crc;
  logic [15:0]   held_bytes;
  logic [15:0]   captured_value;

  logic [CW-1:0] rx_count_next;
  logic [15:0]   rx_crc_next;
  logic [15:0]   held_bytes_next;
  logic [15:0]   captured_value_next;
  logic          rx_ok;

  logic        out_free;
  logic        tx_step;
  logic        tx_last_step;
  logic        in_take;
  logic        take_req;
  logic        take_rx;
  logic        rx_emit;
  logic [7:0]  tx_byte;

  // output register may load when empty or being drained
  assign out_free     = !m_tvalid || m_tready;
  assign tx_step      = tx_busy && out_free;
  assign tx_last_step = tx_step && (tx_idx == 3'(REQ_LEN - 1));

  // requests only need the sequencer; response bytes also need the output
  always_comb begin
    unique case (in_op)
      OP_READ, OP_WRITE: in_take = in_valid && (!tx_busy || tx_last_step);
      OP_RX:             in_take = in_valid && !tx_busy && out_free;
      default:           in_take = in_valid;
    endcase
  end

  assign take_req = in_take && ((in_op == OP_READ) || (in_op == OP_WRITE));
  assign take_rx  = in_take && (in_op == OP_RX);
  assign rx_emit  = take_rx && in_end;
  assign s_tready = !in_valid || in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_op    <= s_tuser;
      in_slave <= s_tdata[7:0];
      in_addr  <= s_tdata[23:8];
      in_wval  <= s_tdata[39:24];
      in_rxb   <= s_tdata[47:40];
      in_end   <= s_tlast;
    end
  end

  // byte being emitted this step
  always_comb begin
    unique case (tx_idx)
      3'd0:    tx_byte = tx_slave;
      3'd1:    tx_byte = tx_fc;
      3'd2:    tx_byte = tx_addr[15:8];
      3'd3:    tx_byte = tx_addr[7:0];
      3'd4:    tx_byte = tx_word[15:8];
      3'd5:    tx_byte = tx_word[7:0];
      3'd6:    tx_byte = tx_crc[7:0];
      default: tx_byte = tx_crc[15:8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_busy <= 1'b0;
      tx_idx  <= '0;
    end else if (take_req) begin
      tx_busy <= 1'b1;
      tx_idx  <= '0;
    end else if (tx_step) begin
      tx_busy <= !tx_last_step;
      tx_idx  <= tx_idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_req) begin
      tx_slave <= in_slave;
      tx_addr  <= in_addr;
      tx_crc   <= CRC_INIT;
      if (in_op == OP_READ) begin
        tx_fc   <= FC_READ_HOLD;
        tx_word <= READ_QUANTITY;
      end else begin
        tx_fc   <= FC_WRITE_ONE;
        tx_word <= in_wval;
      end
    end else if (tx_step && (tx_idx < 3'd6)) begin
      // crc covers the six header bytes as they go out
      tx_crc <= crc16_feed(tx_crc, tx_byte);
    end
  end

  // response byte update; the crc lags two bytes behind the stream
  always_comb begin
    rx_count_next       = rx_count;
    rx_crc_next         = rx_crc;
    held_bytes_next     = held_bytes;
    captured_value_next = captured_value;
    if (rx_count < CW'(RX_FRAME_MAX)) begin
      if (rx_count >= CW'(2)) begin
        rx_crc_next = crc16_feed(rx_crc, held_bytes[15:8]);
      end
      held_bytes_next = {held_bytes[7:0], in_rxb};
      if (rx_count == CW'(3)) begin
        captured_value_next = {in_rxb, captured_value[7:0]};
      end else if (rx_count == CW'(4)) begin
        captured_value_next = {captured_value[15:8], in_rxb};
      end
      rx_count_next = rx_count + CW'(1);
    end
  end

  // trailing two bytes must equal the crc of everything before them
  assign rx_ok = (rx_count_next >= CW'(RX_MIN_LEN)) &&
                 (held_bytes_next[15:8] == rx_crc_next[7:0]) &&
                 (held_bytes_next[7:0] == rx_crc_next[15:8]);

  always_ff @(posedge clk) begin
    if (rst || take_req || rx_emit) begin
      rx_count       <= '0;
      rx_crc         <= CRC_INIT;
      held_bytes     <= '0;
      captured_value <= '0;
    end else if (take_rx) begin
      rx_count       <= rx_count_next;
      rx_crc         <= rx_crc_next;
      held_bytes     <= held_bytes_next;
      captured_value <= captured_value_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= tx_step || rx_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (tx_step) begin
      m_tuser <= KIND_FRAME;
      m_tlast <= (tx_idx == 3'(REQ_LEN - 1));
      m_tdata <= {7'd0, 16'd0, 1'b0, tx_byte};
    end else if (rx_emit) begin
      m_tuser <= KIND_READ;
      m_tlast <= 1'b0;
      m_tdata <= {7'd0, (rx_ok ? captured_value_next : 16'd0), rx_ok, 8'd0};
    end
  end

`ifndef SYNTH
  // a response byte never enters while a request frame is going out
  a_rx_not_during_tx: assert property (@(posedge clk) disable iff (rst)
    take_rx |-> !tx_busy)
    else $error("response byte taken during request emit");

  // after the last emit step the sequencer is idle or restarted at byte 0
  a_tx_wrap: assert property (@(posedge clk) disable iff (rst)
    (tx_last_step && !take_req) |=> !tx_busy)
    else $error("sequencer still busy after last frame byte");

  // receive count never passes the frame maximum
  a_rx_count_bound: assert property (@(posedge clk) disable iff (rst)
    rx_count <= CW'(RX_FRAME_MAX))
    else $error("receive count over frame maximum");

  // a read outcome carries no frame byte and no last flag
  a_outcome_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_READ)) |-> (!m_tlast && (m_tdata[7:0] == 8'd0)))
    else $error("read outcome with frame byte fields set");

  // a failed outcome reports a zero value
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_READ) && !m_tdata[8]) |-> (m_tdata[24:9] == 16'd0))
    else $error("failed outcome with nonzero value");
`endif

endmodule

`default_nettype wire
